// ===== hw/rtl/asei_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package asei_pkg;

   localparam int ANGLE_BITS_DEF      = 32;
   localparam int SINE_ITERATIONS_DEF = 24;

   // cordic working width and start vector
   localparam int CW = 34;
   localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;

   localparam int MUL_W = 64;

   // operation codes
   localparam logic [1:0] OP_TICK    = 2'd0;
   localparam logic [1:0] OP_GRAB    = 2'd1;
   localparam logic [1:0] OP_RELEASE = 2'd2;
   localparam logic [1:0] OP_TOGGLE  = 2'd3;

   // datapath operations
   localparam logic [3:0] DP_NONE  = 4'd0;
   localparam logic [3:0] DP_LATCH = 4'd1;
   localparam logic [3:0] DP_INIT  = 4'd2;
   localparam logic [3:0] DP_ITER  = 4'd3;
   localparam logic [3:0] DP_MUL   = 4'd4;
   localparam logic [3:0] DP_ACCEL = 4'd5;
   localparam logic [3:0] DP_VEL   = 4'd6;
   localparam logic [3:0] DP_ANGLE = 4'd7;
   localparam logic [3:0] DP_APPLY = 4'd8;
   localparam logic [3:0] DP_EMIT  = 4'd9;

   // jump conditions
   localparam logic [2:0] COND_NEXT      = 3'd0;
   localparam logic [2:0] COND_ALWAYS    = 3'd1;
   localparam logic [2:0] COND_NO_REQ    = 3'd2;
   localparam logic [2:0] COND_SKIP      = 3'd3;
   localparam logic [2:0] COND_ITER_MORE = 3'd4;
   localparam logic [2:0] COND_SLOT_BUSY = 3'd5;

   localparam int STEP_W = 4;

   localparam logic [STEP_W-1:0] ST_IDLE  = 4'd0;
   localparam logic [STEP_W-1:0] ST_DISP  = 4'd1;
   localparam logic [STEP_W-1:0] ST_INIT  = 4'd2;
   localparam logic [STEP_W-1:0] ST_ITER  = 4'd3;
   localparam logic [STEP_W-1:0] ST_MUL   = 4'd4;
   localparam logic [STEP_W-1:0] ST_ACCEL = 4'd5;
   localparam logic [STEP_W-1:0] ST_VEL   = 4'd6;
   localparam logic [STEP_W-1:0] ST_ANGLE = 4'd7;
   localparam logic [STEP_W-1:0] ST_APPLY = 4'd8;
   localparam logic [STEP_W-1:0] ST_EMIT  = 4'd9;
   localparam logic [STEP_W-1:0] ST_WRAP  = 4'd10;

   typedef struct packed {
      logic [3:0]        dp;
      logic [2:0]        cond;
      logic [STEP_W-1:0] target;
   } ctrl_type;

   typedef struct packed {
      logic iter_last;
      logic skip_tick;
      logic slot_busy;
   } status_type;

   function automatic ctrl_type ucode(input logic [STEP_W-1:0] step);
      ctrl_type w;
      w = '{dp: DP_NONE, cond: COND_ALWAYS, target: ST_IDLE};
      unique case (step)
         ST_IDLE:  w = '{dp: DP_LATCH, cond: COND_NO_REQ,    target: ST_IDLE};
         ST_DISP:  w = '{dp: DP_NONE,  cond: COND_SKIP,      target: ST_APPLY};
         ST_INIT:  w = '{dp: DP_INIT,  cond: COND_NEXT,      target: ST_IDLE};
         ST_ITER:  w = '{dp: DP_ITER,  cond: COND_ITER_MORE, target: ST_ITER};
         ST_MUL:   w = '{dp: DP_MUL,   cond: COND_NEXT,      target: ST_IDLE};
         ST_ACCEL: w = '{dp: DP_ACCEL, cond: COND_NEXT,      target: ST_IDLE};
         ST_VEL:   w = '{dp: DP_VEL,   cond: COND_NEXT,      target: ST_IDLE};
         ST_ANGLE: w = '{dp: DP_ANGLE, cond: COND_NEXT,      target: ST_IDLE};
         ST_APPLY: w = '{dp: DP_APPLY, cond: COND_NEXT,      target: ST_IDLE};
         ST_EMIT:  w = '{dp: DP_EMIT,  cond: COND_SLOT_BUSY, target: ST_EMIT};
         ST_WRAP:  w = '{dp: DP_NONE,  cond: COND_ALWAYS,    target: ST_IDLE};
         default:  w = '{dp: DP_NONE,  cond: COND_ALWAYS,    target: ST_IDLE};
      endcase
      return w;
   endfunction

   // arctangent of 2^-i in units of 2^-32 turn
   function automatic logic [31:0] atan_turns(input logic [4:0] idx);
      logic [31:0] v;
      v = 32'h0;
      case (idx)
         5'd0:  v = 32'h20000000;
         5'd1:  v = 32'h12E4051E;
         5'd2:  v = 32'h09FB385B;
         5'd3:  v = 32'h051111D4;
         5'd4:  v = 32'h028B0D43;
         5'd5:  v = 32'h0145D7E1;
         5'd6:  v = 32'h00A2F61E;
         5'd7:  v = 32'h00517C55;
         5'd8:  v = 32'h0028BE53;
         5'd9:  v = 32'h00145F2F;
         5'd10: v = 32'h000A2F98;
         5'd11: v = 32'h000517CC;
         5'd12: v = 32'h00028BE6;
         5'd13: v = 32'h000145F3;
         5'd14: v = 32'h0000A2FA;
         5'd15: v = 32'h0000517D;
         5'd16: v = 32'h000028BE;
         5'd17: v = 32'h0000145F;
         5'd18: v = 32'h00000A30;
         5'd19: v = 32'h00000518;
         5'd20: v = 32'h0000028C;
         5'd21: v = 32'h00000146;
         5'd22: v = 32'h000000A3;
         5'd23: v = 32'h00000051;
         5'd24: v = 32'h00000029;
         5'd25: v = 32'h00000014;
         5'd26: v = 32'h0000000A;
         5'd27: v = 32'h00000005;
         5'd28: v = 32'h00000003;
         5'd29: v = 32'h00000001;
         5'd30: v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/asei_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none

module asei_sequencer (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire asei_pkg::status_type  status,
   output asei_pkg::ctrl_type         ctrl,
   output logic                       req_stall
);
   import asei_pkg::*;

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   logic              jump;

   assign ctrl      = ucode(step_ff);
   assign req_stall = (step_ff != ST_IDLE);

   always_comb begin
      unique case (ctrl.cond)
         COND_NEXT:      jump = 1'b0;
         COND_ALWAYS:    jump = 1'b1;
         COND_NO_REQ:    jump = !req_valid;
         COND_SKIP:      jump = status.skip_tick;
         COND_ITER_MORE: jump = !status.iter_last;
         COND_SLOT_BUSY: jump = status.slot_busy;
         default:        jump = 1'b1;
      endcase
      step_in = jump ? ctrl.target : step_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (step_ff == ST_DISP))
      else $error("accepted transaction did not start the program");

   a_emit_waits: assert property (@(posedge clock) disable iff (reset)
      (ctrl.dp == DP_EMIT && status.slot_busy) |=> (step_ff == ST_EMIT))
      else $error("result step left while output slot busy");

endmodule

`default_nettype wire

// ===== hw/rtl/asei_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module asei_datapath #(
   parameter int ANGLE_BITS      = asei_pkg::ANGLE_BITS_DEF,
   parameter int SINE_ITERATIONS = asei_pkg::SINE_ITERATIONS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire asei_pkg::ctrl_type  ctrl,
   output asei_pkg::status_type     status,
   input  wire logic                req_valid,
   input  wire logic [1:0]          req_operation,
   input  wire logic [31:0]         req_angle_in,
   input  wire logic                csr_valid,
   input  wire logic [31:0]         csr_gain,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [31:0]              rsp_angle_out,
   output logic signed [31:0]       rsp_velocity_out,
   output logic signed [31:0]       rsp_accel_out,
   output logic                     rsp_holding,
   output logic                     rsp_paused
);
   import asei_pkg::*;

   localparam int AB     = ANGLE_BITS;
   localparam int ITER_W = (SINE_ITERATIONS > 1) ? $clog2(SINE_ITERATIONS) : 1;
   localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(SINE_ITERATIONS - 1);
   localparam logic [MUL_W-1:0]  HALF      = MUL_W'(1) << (AB - 1);
   localparam logic [MUL_W:0]    RND       = (MUL_W + 1)'(1) << 29;

   // architectural state
   logic [31:0]   gain_ff;
   logic [AB-1:0] angle_ff, velocity_ff, accel_ff;
   logic          hold_ff, pause_ff;

   // transaction latch
   logic [1:0]    op_ff;
   logic [31:0]   angle_in_ff;

   // cordic and multiply
   logic signed [CW-1:0] x_ff, y_ff, z_ff;
   logic [ITER_W-1:0]    iter_ff;
   logic [MUL_W-1:0]     prod_ff;
   logic                 pos_ff;

   // output register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [31:0]   rsp_angle_ff;
   logic [31:0]   rsp_velocity_ff, rsp_accel_ff;
   logic          rsp_holding_ff, rsp_paused_ff;

   logic [AB+31:0]       to_turn_w, from_turn_w;
   logic [31:0]          a32, a_red;
   logic signed [CW-1:0] dx, dy, atan_v;
   logic signed [CW-1:0] y_abs;
   logic [MUL_W-1:0]     prod_in;
   logic [MUL_W:0]       rnd_sum;
   logic [MUL_W-1:0]     r_val, r_lim, r_sat;
   logic [AB-1:0]        accel_in;
   logic                 emit_load;

   assign to_turn_w   = {angle_ff, 32'd0};
   assign a32         = to_turn_w[AB+31:AB];
   assign from_turn_w = {angle_in_ff, {AB{1'b0}}};

   assign a_red  = (a32 + 32'h4000_0000) >> 31 != 32'd0 ? 32'h8000_0000 - a32 : a32;
   assign dx     = y_ff >>> iter_ff;
   assign dy     = x_ff >>> iter_ff;
   assign atan_v = CW'(atan_turns(5'(iter_ff)));

   assign y_abs   = y_ff[CW-1] ? -y_ff : y_ff;
   assign prod_in = {32'd0, y_abs[31:0]} * {32'd0, gain_ff};

   // round half away, saturate, apply sign
   assign rnd_sum  = {1'b0, prod_ff} + RND;
   assign r_val    = MUL_W'(rnd_sum[MUL_W:30]);
   assign r_lim    = pos_ff ? HALF : HALF - 1'b1;
   assign r_sat    = (r_val > r_lim) ? r_lim : r_val;
   assign accel_in = pos_ff ? AB'(-r_sat) : AB'(r_sat);

   assign status.iter_last = (iter_ff == ITER_LAST);
   assign status.skip_tick = (op_ff != OP_TICK) || pause_ff || hold_ff;
   assign status.slot_busy = rsp_valid_ff && rsp_stall;

   assign emit_load    = (ctrl.dp == DP_EMIT) && !status.slot_busy;
   assign rsp_valid_in = emit_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff      <= '0;
         angle_ff     <= '0;
         velocity_ff  <= '0;
         accel_ff     <= '0;
         hold_ff      <= 1'b0;
         pause_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         iter_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            gain_ff <= csr_gain;
         end
         unique case (ctrl.dp)
            DP_INIT: begin
               iter_ff <= '0;
            end
            DP_ITER: begin
               iter_ff <= iter_ff + 1'b1;
            end
            DP_ACCEL: begin
               accel_ff <= accel_in;
            end
            DP_VEL: begin
               velocity_ff <= velocity_ff + accel_ff;
            end
            DP_ANGLE: begin
               angle_ff <= angle_ff + velocity_ff;
            end
            DP_APPLY: begin
               case (op_ff)
                  OP_GRAB: begin
                     angle_ff    <= from_turn_w[AB+31:32];
                     velocity_ff <= '0;
                     accel_ff    <= '0;
                     hold_ff     <= 1'b1;
                  end
                  OP_RELEASE: hold_ff  <= 1'b0;
                  OP_TOGGLE:  pause_ff <= !pause_ff;
                  default: begin
                  end
               endcase
            end
            default: begin
            end
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (ctrl.dp == DP_LATCH && req_valid) begin
         op_ff       <= req_operation;
         angle_in_ff <= req_angle_in;
      end
      if (ctrl.dp == DP_INIT) begin
         x_ff <= CORDIC_X0;
         y_ff <= '0;
         z_ff <= CW'($signed(a_red));
      end
      if (ctrl.dp == DP_ITER) begin
         if (!z_ff[CW-1]) begin
            x_ff <= x_ff - dx;
            y_ff <= y_ff + dy;
            z_ff <= z_ff - atan_v;
         end else begin
            x_ff <= x_ff + dx;
            y_ff <= y_ff - dy;
            z_ff <= z_ff + atan_v;
         end
      end
      if (ctrl.dp == DP_MUL) begin
         prod_ff <= prod_in;
         pos_ff  <= !y_ff[CW-1] && (y_ff != '0);
      end
      if (emit_load) begin
         rsp_angle_ff    <= a32;
         rsp_velocity_ff <= 32'(velocity_ff);
         rsp_accel_ff    <= 32'(accel_ff);
         rsp_holding_ff  <= hold_ff;
         rsp_paused_ff   <= pause_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_angle_out    = rsp_angle_ff;
   assign rsp_velocity_out = $signed(rsp_velocity_ff);
   assign rsp_accel_out    = $signed(rsp_accel_ff);
   assign rsp_holding      = rsp_holding_ff;
   assign rsp_paused       = rsp_paused_ff;

   a_valid_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctrl.dp == DP_EMIT))
      else $error("result valid without result step");

   a_grab_loads: assert property (@(posedge clock) disable iff (reset)
      (ctrl.dp == DP_APPLY && op_ff == OP_GRAB) |=>
         (hold_ff && velocity_ff == '0 && accel_ff == '0))
      else $error("grab did not set hold and clear motion");

endmodule

`default_nettype wire

// ===== hw/rtl/angle_sine_euler_integrator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake            payload
// req_      in         req_valid/req_stall  req_operation, req_angle_in
// rsp_      out        rsp_valid/rsp_stall  rsp_angle_out, rsp_velocity_out, rsp_accel_out,
//                                           rsp_holding, rsp_paused
// csr_      in         csr_valid/csr_ready  csr_gain
//
// a tick runs from accept through dispatch, init, the cordic loop with one rotation per cycle,
// then mul, accel, vel, angle, apply and the result step; the next accept follows the wrap step
// grab, release, toggle and a skipped tick go from dispatch straight to apply and the result step
// reset is synchronous; it clears angle, velocity, acceleration, flags and gain
// req_stall is high whenever the program is not at its idle step; a stalled output holds
// the program at its result step
// a finished transaction sits in the output register while the next one is accepted

module angle_sine_euler_integrator #(
   parameter int ANGLE_BITS      = asei_pkg::ANGLE_BITS_DEF,
   parameter int SINE_ITERATIONS = asei_pkg::SINE_ITERATIONS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_operation,
   input  wire logic [31:0]        req_angle_in,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [31:0]             rsp_angle_out,
   output logic signed [31:0]      rsp_velocity_out,
   output logic signed [31:0]      rsp_accel_out,
   output logic                    rsp_holding,
   output logic                    rsp_paused,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [31:0]        csr_gain
);
   import asei_pkg::*;

   ctrl_type   ctrl;
   status_type status;

   assign csr_ready = 1'b1;

   asei_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .ctrl      (ctrl),
      .req_stall (req_stall)
   );

   asei_datapath #(
      .ANGLE_BITS      (ANGLE_BITS),
      .SINE_ITERATIONS (SINE_ITERATIONS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .status           (status),
      .req_valid        (req_valid),
      .req_operation    (req_operation),
      .req_angle_in     (req_angle_in),
      .csr_valid        (csr_valid),
      .csr_gain         (csr_gain),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_angle_out    (rsp_angle_out),
      .rsp_velocity_out (rsp_velocity_out),
      .rsp_accel_out    (rsp_accel_out),
      .rsp_holding      (rsp_holding),
      .rsp_paused       (rsp_paused)
   );

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import asei_pkg::*;

   localparam int SINE_STEPS = 24;
   localparam logic [31:0] ATAN_TURNS [0:SINE_STEPS-1] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   typedef struct {
      logic [1:0]  op;
      logic [31:0] angle;
   } arm_cmd_type;

   typedef struct {
      logic [31:0]        angle;
      logic signed [31:0] velocity;
      logic signed [31:0] accel;
      logic               holding;
      logic               paused;
   } arm_state_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_operation = OP_TICK;
   logic [31:0] req_angle_in = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_angle_out;
   logic signed [31:0] rsp_velocity_out;
   logic signed [31:0] rsp_accel_out;
   logic        rsp_holding;
   logic        rsp_paused;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_gain = '0;

   arm_cmd_type   cmd_q[$];
   arm_cmd_type   drive_cmd;
   arm_state_type arm_expect_q[$];
   arm_state_type arm = '{angle: '0, velocity: '0, accel: '0, holding: 1'b0, paused: 1'b0};
   arm_state_type seen;
   logic [31:0] gain_model = '0;

   int  send_idle_pct = 0;
   int  stall_pct = 0;
   int  queued_count = 0;
   int  accepted_count = 0;
   int  error_count = 0;
   logic req_taken = 1'b0;

   angle_sine_euler_integrator i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_angle_in     (req_angle_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_angle_out    (rsp_angle_out),
      .rsp_velocity_out (rsp_velocity_out),
      .rsp_accel_out    (rsp_accel_out),
      .rsp_holding      (rsp_holding),
      .rsp_paused       (rsp_paused),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_gain         (csr_gain)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

   function automatic logic signed [63:0] cordic_sine(input logic [31:0] a);
      logic [31:0] r;
      logic [31:0] probe;
      logic signed [63:0] x, y, z, dx, dy;
      r = a;
      probe = a + 32'h40000000;
      // fold the left half plane onto the right one
      if (probe[31])
         r = 32'h80000000 - a;
      z = {{32{r[31]}}, r};
      x = 64'sd652032874;
      y = '0;
      for (int i = 0; i < SINE_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - $signed({32'd0, ATAN_TURNS[i]});
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + $signed({32'd0, ATAN_TURNS[i]});
         end
      end
      return y;
   endfunction

   function automatic logic [31:0] gravity_accel(input logic [31:0] ang, input logic [31:0] g);
      logic signed [63:0] s;
      logic [63:0] mag;
      logic [63:0] r;
      s = cordic_sine(ang);
      mag = (s < 0) ? -s : s;
      r = (mag * {32'd0, g} + (64'd1 << 29)) >> 30;
      if (s > 0) begin
         if (r > 64'h80000000)
            r = 64'h80000000;
         return 32'd0 - r[31:0];
      end
      if (r > 64'h7FFFFFFF)
         r = 64'h7FFFFFFF;
      return r[31:0];
   endfunction

   task automatic advance_arm(input logic [1:0] op, input logic [31:0] angle_in);
      case (op)
         OP_TICK: begin
            if (!arm.paused && !arm.holding) begin
               arm.accel = gravity_accel(arm.angle, gain_model);
               arm.velocity = arm.velocity + arm.accel;
               arm.angle = arm.angle + arm.velocity;
            end
         end
         OP_GRAB: begin
            arm.angle = angle_in;
            arm.velocity = '0;
            arm.accel = '0;
            arm.holding = 1'b1;
         end
         OP_RELEASE: arm.holding = 1'b0;
         OP_TOGGLE: arm.paused = !arm.paused;
         default: ;
      endcase
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch on %s at %0t: got %h expected %h", what, $realtime, got, want);
      error_count++;
   endtask

   // accept side: predict on every accepted request, check every accepted response
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            advance_arm(req_operation, req_angle_in);
            arm_expect_q.push_back(arm);
            accepted_count++;
            req_taken = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (arm_expect_q.size() == 0) begin
               report_mismatch("unexpected transaction", rsp_angle_out, '0);
            end else begin
               seen = arm_expect_q.pop_front();
               if (rsp_angle_out !== seen.angle)
                  report_mismatch("angle_out", rsp_angle_out, seen.angle);
               if (rsp_velocity_out !== seen.velocity)
                  report_mismatch("velocity_out", rsp_velocity_out, seen.velocity);
               if (rsp_accel_out !== seen.accel)
                  report_mismatch("accel_out", rsp_accel_out, seen.accel);
               if (rsp_holding !== seen.holding)
                  report_mismatch("holding", rsp_holding, seen.holding);
               if (rsp_paused !== seen.paused)
                  report_mismatch("paused", rsp_paused, seen.paused);
            end
         end
      end
   end

   always @(negedge clock) begin
      if (!reset && (req_taken || !req_valid)) begin
         req_taken = 1'b0;
         if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            drive_cmd = cmd_q.pop_front();
            req_valid <= 1'b1;
            req_operation <= drive_cmd.op;
            req_angle_in <= drive_cmd.angle;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   task automatic post_cmd(input logic [1:0] op, input logic [31:0] angle);
      cmd_q.push_back('{op: op, angle: angle});
      queued_count++;
   endtask

   task automatic wait_drained();
      do
         @(negedge clock);
      while (accepted_count != queued_count || arm_expect_q.size() != 0);
      @(posedge clock);
   endtask

   task automatic write_gain(input logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_gain <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      gain_model = value;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] boundary_angle();
      case ($urandom_range(5))
         0: return 32'h00000000;
         1: return 32'h40000000;
         2: return 32'h80000000;
         3: return 32'hC0000000;
         4: return 32'h3FFFFFFF;
         default: return 32'hFFFFFFFF;
      endcase
   endfunction

   // mostly ticks; grabs are usually followed by a release, pauses are usually undone
   task automatic queue_random_cmds(input int count);
      int left;
      int pick;
      logic [31:0] angle;
      left = count;
      while (left > 0) begin
         pick = $urandom_range(99);
         angle = $urandom;
         if (pick < 62) begin
            post_cmd(OP_TICK, angle);
            left--;
         end else if (pick < 80) begin
            if ($urandom_range(3) == 0)
               angle = boundary_angle();
            post_cmd(OP_GRAB, angle);
            left--;
            if ($urandom_range(9) != 0) begin
               post_cmd(OP_RELEASE, $urandom);
               left--;
            end
         end else if (pick < 92) begin
            post_cmd(OP_RELEASE, angle);
            left--;
         end else begin
            post_cmd(OP_TOGGLE, angle);
            left--;
            if ($urandom_range(4) != 0) begin
               repeat ($urandom_range(2)) begin
                  post_cmd(OP_TICK, $urandom);
                  left--;
               end
               post_cmd(OP_TOGGLE, $urandom);
               left--;
            end
         end
      end
   endtask

   task automatic run_random_phase(input int idle, input int stall, input logic [31:0] g,
                                   input int count);
      write_gain(g);
      send_idle_pct = idle;
      stall_pct = stall;
      queue_random_cmds(count / 2);
      // hold the sender until everything in flight has come back
      wait_drained();
      queue_random_cmds(count - count / 2);
      wait_drained();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // gain still at its reset value
      post_cmd(OP_TICK, 32'h00000000);
      post_cmd(OP_TOGGLE, 32'h00000000);
      post_cmd(OP_TICK, 32'hFFFFFFFF);
      post_cmd(OP_GRAB, 32'hFFFFFFFF);
      post_cmd(OP_TICK, 32'h00000000);
      post_cmd(OP_RELEASE, 32'h00000000);
      post_cmd(OP_TOGGLE, 32'hFFFFFFFF);
      post_cmd(OP_RELEASE, 32'h00000000);
      post_cmd(OP_TICK, 32'h00000000);
      wait_drained();

      // full-scale gain drives the acceleration into saturation
      write_gain(32'hFFFFFFFF);
      post_cmd(OP_GRAB, 32'h40000000);
      post_cmd(OP_RELEASE, 32'h00000000);
      post_cmd(OP_TICK, 32'h00000000);
      post_cmd(OP_TICK, 32'h00000000);
      post_cmd(OP_GRAB, 32'hC0000000);
      post_cmd(OP_RELEASE, 32'h00000000);
      post_cmd(OP_TICK, 32'h00000000);
      post_cmd(OP_GRAB, 32'h80000000);
      post_cmd(OP_RELEASE, 32'h00000000);
      post_cmd(OP_TICK, 32'h00000000);
      post_cmd(OP_GRAB, 32'h00000000);
      post_cmd(OP_RELEASE, 32'h00000000);
      post_cmd(OP_TICK, 32'h00000000);
      post_cmd(OP_GRAB, 32'h3FFFFFFF);
      post_cmd(OP_RELEASE, 32'h00000000);
      post_cmd(OP_TICK, 32'h00000000);
      wait_drained();

      run_random_phase(0, 0, $urandom_range(32'h00100000, 1), 120);
      run_random_phase(55, 0, 32'h00000000, 120);
      run_random_phase(0, 55, 32'hFFFFFFFF, 120);
      run_random_phase(35, 35, $urandom, 120);
      run_random_phase(35, 35, 32'h00000001, 120);

      repeat (60) @(posedge clock);
      if (error_count == 0 && arm_expect_q.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
